### src/safe_relative_uri_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// safe relative uri decoder assertion macros
// assertion wrappers used by the rtl top of the decoder
// ----------------------------------------------------------------------------
`ifndef SAFE_RELATIVE_URI_DECODER_TOP_DEFINES_SVH
`define SAFE_RELATIVE_URI_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define SRUD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("srud assertion failed");
// checked during reset as well
`define SRUD_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("srud reset assertion failed");
`else
`define SRUD_ASSERT(lbl, prop)
`define SRUD_ASSERT_RST(lbl, prop)
`endif

`endif

### src/srud_pkg.sv
// ----------------------------------------------------------------------------
// srud_pkg
// types, character codes and helpers of the safe relative uri decoder
// ----------------------------------------------------------------------------
`default_nettype none

package srud_pkg;

    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;
    localparam logic [3:0] HEX_ALPHA    = 4'd10;

    localparam logic [1:0] SEG_LEN_MAX  = 2'd3;
    localparam logic [1:0] SEG_LEN_DOTS = 2'd2;

    typedef enum logic [2:0] {
        ESC_NORMAL = 3'b001,
        ESC_HIGH   = 3'b010,
        ESC_LOW    = 3'b100
    } t_esc;

    typedef struct packed {
        t_esc       esc;
        logic [3:0] high_nibble;
        logic       any_decoded;
        logic [1:0] seg_len;
        logic       seg_dots;
        logic       failed;
    } t_state;

    localparam t_state ST_RESET = '{
        esc:         ESC_NORMAL,
        high_nibble: 4'd0,
        any_decoded: 1'b0,
        seg_len:     2'd0,
        seg_dots:    1'b1,
        failed:      1'b0
    };

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       done;
        logic       ok;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.valid = 1'b1;
            h.value = 4'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LF) begin
            h.valid = 1'b1;
            h.value = 4'(c - CH_LA) + HEX_ALPHA;
        end else if (c >= CH_UA && c <= CH_UF) begin
            h.valid = 1'b1;
            h.value = 4'(c - CH_UA) + HEX_ALPHA;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### src/srud_step.sv
// ----------------------------------------------------------------------------
// srud_step
// next state and result of the decoder for one encoded byte
// ----------------------------------------------------------------------------
`default_nettype none

module srud_step (
    input  wire srud_pkg::t_state i_state,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_present,
    input  wire logic         i_last,
    output srud_pkg::t_state  o_state,
    output srud_pkg::t_result o_result
);
    import srud_pkg::*;

    t_state  ns;
    t_hex    hx;
    logic    emit;
    logic [7:0] dec;
    logic    ok;

    always_comb begin
        ns   = i_state;
        hx   = hex_decode(i_byte);
        emit = 1'b0;
        dec  = 8'd0;
        if (i_present && !i_state.failed) begin
            case (i_state.esc)
                ESC_HIGH: begin
                    if (!hx.valid) begin
                        ns.failed = 1'b1;
                    end else begin
                        ns.high_nibble = hx.value;
                        ns.esc         = ESC_LOW;
                    end
                end
                ESC_LOW: begin
                    if (!hx.valid) begin
                        ns.failed = 1'b1;
                    end else begin
                        dec    = {i_state.high_nibble, hx.value};
                        ns.esc = ESC_NORMAL;
                        emit   = 1'b1;
                    end
                end
                default: begin
                    ns.esc = ESC_NORMAL;
                    if (i_byte == CH_PERCENT) begin
                        ns.esc = ESC_HIGH;
                    end else begin
                        dec  = i_byte;
                        emit = 1'b1;
                    end
                end
            endcase
            if (emit) begin
                ns.any_decoded = 1'b1;
                if (dec == CH_SLASH || dec == CH_BACKSLASH) begin
                    if (i_state.seg_len == 2'd0) begin
                        ns.failed = 1'b1;
                    end
                    if (i_state.seg_len == SEG_LEN_DOTS && i_state.seg_dots) begin
                        ns.failed = 1'b1;
                    end
                    ns.seg_len  = 2'd0;
                    ns.seg_dots = 1'b1;
                end else begin
                    if (dec == CH_COLON || dec == CH_NUL) begin
                        ns.failed = 1'b1;
                    end
                    if (i_state.seg_len != SEG_LEN_MAX) begin
                        ns.seg_len = i_state.seg_len + 2'd1;
                    end
                    if (dec != CH_DOT) begin
                        ns.seg_dots = 1'b0;
                    end
                end
            end
        end
        ok = !ns.failed && ns.any_decoded && (ns.esc == ESC_NORMAL)
             && !(ns.seg_len == SEG_LEN_DOTS && ns.seg_dots);
        o_result.emit = emit;
        o_result.data = dec;
        o_result.done = i_last;
        o_result.ok   = i_last && ok;
        o_state       = i_last ? ST_RESET : ns;
    end

endmodule

`default_nettype wire

### src/safe_relative_uri_decoder_top.sv
// ----------------------------------------------------------------------------
// safe_relative_uri_decoder_top
// percent decoder and safety check for a relative uri path, one byte per item
// ----------------------------------------------------------------------------
// output: each accepted item's result is captured in the output register
// throughput: 1 item per cycle while the output is not stalled, limited by the single output register stage
// reset: synchronous active low, clears the running path state and the
//        output valid; the next string starts fresh after every tlast
`default_nettype none
`include "safe_relative_uri_decoder_top_defines.svh"

module safe_relative_uri_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // in_byte
    input  wire logic        i_s_axis_tuser,   // byte_present
    input  wire logic        i_s_axis_tlast,   // is_last
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // out_byte, accepted, zero pad
    output logic             o_m_axis_tuser,   // out_valid
    output logic             o_m_axis_tlast    // done_res
);
    import srud_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_out;
    t_result r_out;
    logic    r_m_valid;
    logic    s_fire;

    srud_step u_step (
        .i_state   (r_state),
        .i_byte    (i_s_axis_tdata),
        .i_present (i_s_axis_tuser),
        .i_last    (i_s_axis_tlast),
        .o_state   (n_state),
        .o_result  (n_out)
    );

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RESET;
            r_m_valid <= 1'b0;
        end else if (s_fire) begin
            r_state   <= n_state;
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.ok, r_out.data};
    assign o_m_axis_tuser  = r_out.emit;
    assign o_m_axis_tlast  = r_out.done;

    `SRUD_ASSERT(a_last_clears_state, s_fire && i_s_axis_tlast |=> r_state == ST_RESET)
    `SRUD_ASSERT(a_verdict_only_on_last, r_m_valid && !r_out.done |-> !r_out.ok)
    `SRUD_ASSERT(a_no_byte_without_emit, r_m_valid && !r_out.emit |-> r_out.data == 8'd0)
    `SRUD_ASSERT(a_failed_blocks_emit, s_fire && r_state.failed |=> !r_out.emit)
    `SRUD_ASSERT(a_stall_blocks_input, r_m_valid && !i_m_axis_tready |-> !o_s_axis_tready)
    `SRUD_ASSERT_RST(a_reset_clears_valid, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

`default_nettype wire
